[rtl/ata_identify_block_parser_assert.svh]
// assertion macros shared by the identify block parser rtl
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef ATA_IDENTIFY_BLOCK_PARSER_ASSERT_SVH
`define ATA_IDENTIFY_BLOCK_PARSER_ASSERT_SVH

// same-cycle implication
`define ATA_ID_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATA_ID_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ata_id_pkg.sv]
// shared types and constants for the identify block parser
// no dependencies
package ata_id_pkg;

  localparam int unsigned POS_W = 8;

  typedef enum logic [1:0] {
    KIND_SERIAL  = 2'd0,
    KIND_MODEL   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  // fixed word positions inside the identify block
  localparam logic [POS_W-1:0] WORD_COUNT28_LO = 8'd60;
  localparam logic [POS_W-1:0] WORD_COUNT28_HI = 8'd61;
  localparam logic [POS_W-1:0] WORD_FEATURES   = 8'd83;
  localparam logic [POS_W-1:0] WORD_COUNT48_0  = 8'd100;
  localparam logic [POS_W-1:0] WORD_COUNT48_1  = 8'd101;
  localparam logic [POS_W-1:0] WORD_COUNT48_2  = 8'd102;
  localparam logic [POS_W-1:0] WORD_COUNT48_3  = 8'd103;
  localparam logic [POS_W-1:0] WORD_SECTOR_CFG = 8'd106;
  localparam logic [POS_W-1:0] WORD_SIZE_LO    = 8'd117;
  localparam logic [POS_W-1:0] WORD_SIZE_HI    = 8'd118;

  localparam int unsigned LBA48_BIT      = 10;
  localparam int unsigned LARGE_SECT_BIT = 12;
  localparam logic [1:0]  SIG_VALID      = 2'b01;
  localparam logic [31:0] DEFAULT_SIZE   = 32'd512;

  typedef struct packed {
    logic        identified;
    logic [5:0]  model_length;
    logic [4:0]  serial_length;
    logic [31:0] sector_size;
    logic [63:0] total_sectors;
    logic        lba48_supported;
    logic [7:0]  char_second;
    logic [7:0]  char_first;
    logic [5:0]  char_position;
    kind_t       kind;
  } result_t;

endpackage

[rtl/ata_identify_block_parser.sv]
// top level of the identify block parser: input register, core, result register
// depends on ata_id_pkg, ata_id_core and ata_identify_block_parser_assert.svh
//
//   channel   dir  tdata                              tuser
//   s_*       in   identify_word [15:0]               -
//   m_*       out  char/summary fields, 131 of 136    kind [1:0]
//
// one item per cycle while m_tready is high; an item taken on s_* is held in the input
// register, then loaded into the result register, and from there is offered on m_*
// the word counter in the core sets the position; it wraps after the last word
// rst is synchronous and clears position, captured words and trim lengths
// a stalled result holds the input register, which then fills and drops s_tready
// words that yield no result pass through without waiting on m_tready
`include "ata_identify_block_parser_assert.svh"

module ata_identify_block_parser
  import ata_id_pkg::*;
#(
  parameter int unsigned BLOCK_WORDS  = 256,
  parameter int unsigned SERIAL_START = 10,
  parameter int unsigned SERIAL_WORDS = 10,
  parameter int unsigned MODEL_START  = 27,
  parameter int unsigned MODEL_WORDS  = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // identify_word
  output logic         m_tvalid,
  input  logic         m_tready,
  // char_position[5:0], char_first[13:6], char_second[21:14], lba48_supported[22],
  // total_sectors[86:23], sector_size[118:87], serial_length[123:119],
  // model_length[129:124], identified[130], zero fill[135:131]
  output logic [135:0] m_tdata,
  output logic [1:0]   m_tuser    // kind
);

  // input register
  logic        in_valid;
  logic [15:0] in_word;
  logic        advance;

  // core result and result register
  logic    res_valid;
  result_t res;
  result_t out_res;

  // an item moves on unless it makes a result and the result register is full and not being taken
  assign advance  = in_valid && (!res_valid || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata;
    end
  end

  ata_id_core #(
    .BLOCK_WORDS  (BLOCK_WORDS),
    .SERIAL_START (SERIAL_START),
    .SERIAL_WORDS (SERIAL_WORDS),
    .MODEL_START  (MODEL_START),
    .MODEL_WORDS  (MODEL_WORDS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .word      (in_word),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  // pack result fields, lowest first
  assign m_tuser = out_res.kind;
  assign m_tdata = {5'd0,
                    out_res.identified,
                    out_res.model_length,
                    out_res.serial_length,
                    out_res.sector_size,
                    out_res.total_sectors,
                    out_res.lba48_supported,
                    out_res.char_second,
                    out_res.char_first,
                    out_res.char_position};

  `ATA_ID_ASSERT_NXT(a_in_hold, in_valid && !advance, in_valid && $stable(in_word), "input register lost a stalled item")
  `ATA_ID_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_res), "result changed while stalled")
  `ATA_ID_ASSERT_IMP(a_identified, m_tvalid && out_res.kind == KIND_SUMMARY, out_res.identified == (out_res.total_sectors != 64'd0), "identified flag disagrees with sector total")

endmodule

[rtl/ata_id_core.sv]
// word position tracking, field capture, trim lengths and result formation
// depends on ata_id_pkg and ata_identify_block_parser_assert.svh
`include "ata_identify_block_parser_assert.svh"

module ata_id_core
  import ata_id_pkg::*;
#(
  parameter int unsigned BLOCK_WORDS  = 256,
  parameter int unsigned SERIAL_START = 10,
  parameter int unsigned SERIAL_WORDS = 10,
  parameter int unsigned MODEL_START  = 27,
  parameter int unsigned MODEL_WORDS  = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [15:0]   word,
  output logic          res_valid,
  output result_t       res
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_WORDS - 1);
  localparam logic [POS_W-1:0] S_START  = POS_W'(SERIAL_START);
  localparam logic [POS_W:0]   S_WORDS  = (POS_W+1)'(SERIAL_WORDS);
  localparam logic [POS_W-1:0] M_START  = POS_W'(MODEL_START);
  localparam logic [POS_W:0]   M_WORDS  = (POS_W+1)'(MODEL_WORDS);

  logic [POS_W-1:0] word_position, word_position_next;
  logic [31:0]      small_count, small_count_next;
  logic [63:0]      large_count, large_count_next;
  logic             lba48_flag, lba48_flag_next;
  logic [15:0]      sizing_word, sizing_word_next;
  logic [31:0]      words_per_sector, words_per_sector_next;
  logic [4:0]       serial_kept, serial_kept_next;
  logic [5:0]       model_kept, model_kept_next;

  logic [7:0]     hi, lo;
  logic [POS_W:0] s_off, m_off;
  logic           in_serial, in_model, at_last;
  logic [POS_W:0] sidx, midx;
  logic [4:0]     s_trim;
  logic [5:0]     m_trim;
  logic [63:0]    count;
  logic           size_ok;

  assign hi        = word[15:8];
  assign lo        = word[7:0];
  assign s_off     = {1'b0, word_position} - {1'b0, S_START};
  assign m_off     = {1'b0, word_position} - {1'b0, M_START};
  assign in_serial = (word_position >= S_START) && (s_off < S_WORDS);
  assign in_model  = (word_position >= M_START) && (m_off < M_WORDS);
  assign at_last   = (word_position >= LAST_POS);
  assign sidx      = {s_off[POS_W-1:0], 1'b0};
  assign midx      = {m_off[POS_W-1:0], 1'b0};

  // running last-non-space length
  always_comb begin
    s_trim = serial_kept;
    if (hi != SPACE_BYTE) s_trim = 5'(sidx + 1'b1);
    if (lo != SPACE_BYTE) s_trim = 5'(sidx + 2'd2);
    m_trim = model_kept;
    if (hi != SPACE_BYTE) m_trim = 6'(midx + 1'b1);
    if (lo != SPACE_BYTE) m_trim = 6'(midx + 2'd2);
  end

  always_comb begin
    serial_kept_next      = in_serial ? s_trim : serial_kept;
    model_kept_next       = in_model ? m_trim : model_kept;
    lba48_flag_next       = lba48_flag;
    small_count_next      = small_count;
    large_count_next      = large_count;
    sizing_word_next      = sizing_word;
    words_per_sector_next = words_per_sector;
    if (word_position == WORD_FEATURES)   lba48_flag_next = word[LBA48_BIT];
    if (word_position == WORD_COUNT28_LO) small_count_next[15:0] = word;
    if (word_position == WORD_COUNT28_HI) small_count_next[31:16] = word;
    if (word_position == WORD_COUNT48_0)  large_count_next[15:0] = word;
    if (word_position == WORD_COUNT48_1)  large_count_next[31:16] = word;
    if (word_position == WORD_COUNT48_2)  large_count_next[47:32] = word;
    if (word_position == WORD_COUNT48_3)  large_count_next[63:48] = word;
    if (word_position == WORD_SECTOR_CFG) sizing_word_next = word;
    if (word_position == WORD_SIZE_LO)    words_per_sector_next[15:0] = word;
    if (word_position == WORD_SIZE_HI)    words_per_sector_next[31:16] = word;
    word_position_next = at_last ? '0 : word_position + 1'b1;
  end

  assign count   = lba48_flag ? large_count : {32'd0, small_count};
  assign size_ok = (sizing_word[15:14] == SIG_VALID) && sizing_word[LARGE_SECT_BIT] &&
                   (words_per_sector != 32'd0) && !words_per_sector[31];

  always_comb begin
    res           = '0;
    res.kind      = KIND_SERIAL;
    res_valid     = 1'b0;
    if (at_last) begin
      res_valid           = 1'b1;
      res.kind            = KIND_SUMMARY;
      res.lba48_supported = lba48_flag;
      res.total_sectors   = count;
      res.sector_size     = size_ok ? {words_per_sector[30:0], 1'b0} : DEFAULT_SIZE;
      res.serial_length   = serial_kept_next;
      res.model_length    = model_kept_next;
      res.identified      = (count != 64'd0);
    end else if (in_serial) begin
      res_valid         = 1'b1;
      res.kind          = KIND_SERIAL;
      res.char_position = sidx[5:0];
      res.char_first    = hi;
      res.char_second   = lo;
    end else if (in_model) begin
      res_valid         = 1'b1;
      res.kind          = KIND_MODEL;
      res.char_position = midx[5:0];
      res.char_first    = hi;
      res.char_second   = lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position    <= '0;
      small_count      <= '0;
      large_count      <= '0;
      lba48_flag       <= 1'b0;
      sizing_word      <= '0;
      words_per_sector <= '0;
      serial_kept      <= '0;
      model_kept       <= '0;
    end else if (fire) begin
      word_position    <= word_position_next;
      small_count      <= small_count_next;
      large_count      <= large_count_next;
      lba48_flag       <= lba48_flag_next;
      sizing_word      <= sizing_word_next;
      words_per_sector <= words_per_sector_next;
      serial_kept      <= at_last ? '0 : serial_kept_next;
      model_kept       <= at_last ? '0 : model_kept_next;
    end
  end

  `ATA_ID_ASSERT_NXT(a_wrap_at_last, fire && at_last, word_position == '0 && serial_kept == '0 && model_kept == '0, "position or lengths not cleared at block end")
  `ATA_ID_ASSERT_IMP(a_summary_only_last, res_valid && res.kind == KIND_SUMMARY, at_last && res.char_position == '0, "summary away from the last word")
  `ATA_ID_ASSERT_IMP(a_char_pos_even, res_valid && res.kind != KIND_SUMMARY, res.char_position[0] == 1'b0, "character position not on a word boundary")

endmodule
